// File: rtl/assert_macros.svh
// Assertion macros used by cluster_debug_halt_controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define CDH_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define CDH_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define CDH_ASSERT(lbl, prop, msg)
`define CDH_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// File: rtl/cdh_pkg.sv
package cdh_pkg;

    localparam int BootSlots  = 8;
    localparam int CoreIdxW   = 3;
    localparam int DataW      = 32;
    localparam int LineW      = 8;
    localparam logic [DataW-1:0] BootReset = 32'h5757_5757;

    localparam int InTdataW   = 40;
    localparam int InTuserW   = 5;
    localparam int OutTdataW  = 88;

    typedef enum logic [1:0] {
        ACT_READ  = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_HALT  = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        REG_FETCH    = 3'd0,
        REG_BOOT     = 3'd1,
        REG_EVENT    = 3'd2,
        REG_CFG      = 3'd3,
        REG_CLKGATE  = 3'd4,
        REG_DBG_STAT = 3'd5,
        REG_DBG_MASK = 3'd6,
        REG_UNMAPPED = 3'd7
    } t_reg_code;

    typedef struct packed {
        t_action               action;
        t_reg_code             register_code;
        logic [CoreIdxW-1:0]   core_index;
        logic [DataW-1:0]      write_data;
        logic                  access_is_word;
        logic                  reported_halt;
    } t_item;

    // Member order makes read_data land in the lowest bits.
    typedef struct packed {
        logic [DataW-1:0]      boot_value;
        logic [CoreIdxW-1:0]   boot_core;
        logic                  boot_update;
        logic [LineW-1:0]      halt_lines;
        logic                  fetch_updated;
        logic [LineW-1:0]      fetch_lines;
        logic                  access_error;
        logic [DataW-1:0]      read_data;
    } t_result;

endpackage

// File: rtl/cluster_debug_halt_controller.sv
// Channel    Dir  Bus      Beat contents (low bit up)
// s_axis     in   tdata    core_index, write_data, access_is_word, reported_halt
//            in   tuser    action, register_code
// m_axis     out  tdata    read_data, access_error, fetch_lines, fetch_updated,
//                          halt_lines, boot_update, boot_core, boot_value
//
// One beat per cycle in and out unless m_axis stalls.
// A taken beat passes the input register, the decode and the result register to m_axis.
// Synchronous active-low reset clears status, mask and fetch, and sets boot addresses.
// A stall on m_axis holds the result; s_axis keeps taking one more beat, then stalls.
`include "assert_macros.svh"

module cluster_debug_halt_controller #(
    parameter int NUM_CORES = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // core_index[2:0], write_data[34:3], access_is_word[35], reported_halt[36]
    input  logic [cdh_pkg::InTdataW-1:0]    s_axis_tdata,
    // action[1:0], register_code[4:2]
    input  logic [cdh_pkg::InTuserW-1:0]    s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // read_data[31:0], access_error[32], fetch_lines[40:33], fetch_updated[41],
    // halt_lines[49:42], boot_update[50], boot_core[53:51], boot_value[85:54]
    output logic [cdh_pkg::OutTdataW-1:0]   m_axis_tdata
);
    import cdh_pkg::*;

    localparam logic [DataW:0] CoreMaskWide = (33'd1 << NUM_CORES) - 33'd1;
    localparam logic [LineW-1:0] LineMask   = CoreMaskWide[LineW-1:0];

    logic    w_in_vld;
    t_item   w_item;
    logic    w_out_free;
    logic    w_advance;
    t_result w_result;

    assign w_advance = w_in_vld && w_out_free;

    cdh_in_reg u_in_reg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .i_take        (w_advance),
        .o_vld         (w_in_vld),
        .o_item        (w_item)
    );

    cdh_regs #(
        .NUM_CORES (NUM_CORES)
    ) u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (w_advance),
        .i_item    (w_item),
        .o_result  (w_result)
    );

    cdh_out_reg u_out_reg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (w_advance),
        .i_result      (w_result),
        .o_free        (w_out_free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    `CDH_ASSERT(a_absent_core_no_halt, w_advance |-> ((w_result.halt_lines & ~LineMask) == '0), "halt line driven for absent core")
    `CDH_ASSERT(a_absent_core_no_fetch, w_advance |-> ((w_result.fetch_lines & ~LineMask) == '0), "fetch line driven for absent core")
    `CDH_ASSERT(a_update_no_error, (w_advance && (w_result.boot_update || w_result.fetch_updated)) |-> !w_result.access_error, "update flagged together with error")
    `CDH_ASSERT(a_pipe_moves, (w_in_vld && !m_axis_tvalid) |=> m_axis_tvalid, "held beat not moved to free output")
    `CDH_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> (!m_axis_tvalid && s_axis_tready), "pipeline not empty after reset")

endmodule

// File: rtl/cdh_in_reg.sv
module cdh_in_reg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [cdh_pkg::InTdataW-1:0]   s_axis_tdata,
    input  logic [cdh_pkg::InTuserW-1:0]   s_axis_tuser,
    input  logic                           i_take,
    output logic                           o_vld,
    output cdh_pkg::t_item                 o_item
);
    import cdh_pkg::*;

    logic  r_vld;
    logic  n_vld;
    t_item r_item;
    t_item n_item;
    logic  w_accept;

    assign s_axis_tready = !r_vld || i_take;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    always_comb begin
        n_vld  = r_vld;
        n_item = r_item;
        if (i_take) begin
            n_vld = 1'b0;
        end
        if (w_accept) begin
            n_vld                 = 1'b1;
            n_item.action         = t_action'(s_axis_tuser[1:0]);
            n_item.register_code  = t_reg_code'(s_axis_tuser[4:2]);
            n_item.core_index     = s_axis_tdata[2:0];
            n_item.write_data     = s_axis_tdata[34:3];
            n_item.access_is_word = s_axis_tdata[35];
            n_item.reported_halt  = s_axis_tdata[36];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
        r_item <= n_item;
    end

    assign o_vld  = r_vld;
    assign o_item = r_item;

endmodule

// File: rtl/cdh_regs.sv
module cdh_regs #(
    parameter int NUM_CORES = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_advance,
    input  cdh_pkg::t_item   i_item,
    output cdh_pkg::t_result o_result
);
    import cdh_pkg::*;

    localparam logic [DataW:0]   CoreMaskWide = (33'd1 << NUM_CORES) - 33'd1;
    localparam logic [DataW-1:0] CoreMask     = CoreMaskWide[DataW-1:0];
    localparam logic [5:0]       NumCoresW    = 6'(NUM_CORES);

    logic [DataW-1:0] r_halt_status;
    logic [DataW-1:0] n_halt_status;
    logic [DataW-1:0] r_halt_mask;
    logic [DataW-1:0] n_halt_mask;
    logic [LineW-1:0] r_fetch;
    logic [LineW-1:0] n_fetch;
    logic [DataW-1:0] r_boot [BootSlots];

    logic             w_core_ok;
    logic             w_trig;
    logic             w_boot_wr;
    logic [DataW-1:0] w_core_bit;
    logic [DataW-1:0] w_status;
    logic [DataW-1:0] w_hit;
    t_result          w_res;

    assign w_core_ok  = {3'b000, i_item.core_index} < NumCoresW;
    assign w_core_bit = DataW'(1) << i_item.core_index;

    always_comb begin
        w_res         = '0;
        w_status      = r_halt_status;
        n_halt_mask   = r_halt_mask;
        n_fetch       = r_fetch;
        w_trig        = 1'b0;
        w_boot_wr     = 1'b0;
        if (i_item.action == ACT_HALT) begin
            if (w_core_ok) begin
                w_status = (r_halt_status & ~w_core_bit)
                         | (i_item.reported_halt ? w_core_bit : '0);
                w_trig   = i_item.reported_halt;
            end
        end else if (i_item.action == ACT_READ || i_item.action == ACT_WRITE) begin
            if (!i_item.access_is_word) begin
                w_res.access_error = 1'b1;
            end else begin
                unique case (i_item.register_code) inside
                    REG_FETCH: begin
                        if (i_item.action == ACT_WRITE) begin
                            n_fetch             = i_item.write_data[LineW-1:0]
                                                & CoreMask[LineW-1:0];
                            w_res.fetch_updated = 1'b1;
                        end
                    end
                    REG_BOOT: begin
                        if (!w_core_ok) begin
                            w_res.access_error = 1'b1;
                        end else if (i_item.action == ACT_WRITE) begin
                            w_boot_wr         = 1'b1;
                            w_res.boot_update = 1'b1;
                            w_res.boot_core   = i_item.core_index;
                            w_res.boot_value  = i_item.write_data;
                        end else begin
                            w_res.read_data = r_boot[i_item.core_index];
                        end
                    end
                    REG_EVENT, REG_CFG, REG_CLKGATE: begin
                    end
                    REG_DBG_STAT: begin
                        if (i_item.action == ACT_WRITE) begin
                            w_status = r_halt_status & ~i_item.write_data;
                            w_trig   = 1'b1;
                        end else begin
                            w_res.read_data = r_halt_status;
                        end
                    end
                    REG_DBG_MASK: begin
                        if (i_item.action == ACT_WRITE) begin
                            n_halt_mask = i_item.write_data;
                            w_trig      = 1'b1;
                        end else begin
                            w_res.read_data = r_halt_mask;
                        end
                    end
                    default: begin
                        w_res.access_error = 1'b1;
                    end
                endcase
            end
        end
        w_hit         = w_status & n_halt_mask;
        n_halt_status = w_status;
        if (w_trig && w_hit != '0 && w_hit != n_halt_mask) begin
            n_halt_status = w_status | n_halt_mask;
        end
        w_res.fetch_lines = n_fetch;
        w_res.halt_lines  = n_halt_status[LineW-1:0] & CoreMask[LineW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_halt_status <= '0;
            r_halt_mask   <= '0;
            r_fetch       <= '0;
            for (int i = 0; i < BootSlots; i++) begin
                r_boot[i] <= BootReset;
            end
        end else if (i_advance) begin
            r_halt_status <= n_halt_status;
            r_halt_mask   <= n_halt_mask;
            r_fetch       <= n_fetch;
            if (w_boot_wr) begin
                r_boot[i_item.core_index] <= i_item.write_data;
            end
        end
    end

    assign o_result = w_res;

endmodule

// File: rtl/cdh_out_reg.sv
module cdh_out_reg (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_load,
    input  cdh_pkg::t_result                i_result,
    output logic                            o_free,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [cdh_pkg::OutTdataW-1:0]   m_axis_tdata
);
    import cdh_pkg::*;

    logic    r_vld;
    logic    n_vld;
    t_result r_res;

    assign o_free = !r_vld || m_axis_tready;

    always_comb begin
        n_vld = r_vld;
        if (m_axis_tready) begin
            n_vld = 1'b0;
        end
        if (i_load) begin
            n_vld = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
        if (i_load) begin
            r_res <= i_result;
        end
    end

    assign m_axis_tvalid = r_vld;
    assign m_axis_tdata  = {(OutTdataW - $bits(t_result))'(0), r_res};

endmodule
